/* hdl/pfd_pkg.sv */
package pfd_pkg;

  localparam int GRID_SIDE  = 5;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int ALPHABET   = 26;
  localparam int LETTER_J   = 9;

  localparam int LETTER_W = 5;
  localparam int OP_W     = 2;
  localparam int IDX_W    = $clog2(CELL_COUNT + 1);
  localparam int RC_W     = $clog2(GRID_SIDE);
  localparam int POS_W    = 2 * RC_W;

  typedef enum logic [OP_W-1:0] {
    OP_KEY     = 2'd0,
    OP_FINISH  = 2'd1,
    OP_DECRYPT = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
  } pos_t;

  // One queued command, already classified by the front end.
  typedef struct packed {
    opcode_t               op;
    logic [LETTER_W-1:0]   first;
    logic [LETTER_W-1:0]   second;
    logic                  first_bad;
    logic                  second_bad;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS_B,
    ST_CALC,
    ST_CELL2,
    ST_EMIT
  } back_state_t;

  // j and codes past z never sit in the square
  function automatic logic letter_bad(input logic [LETTER_W-1:0] l);
    return (l >= LETTER_W'(ALPHABET)) || (l == LETTER_W'(LETTER_J));
  endfunction

  function automatic pos_t idx_to_pos(input logic [IDX_W-1:0] idx);
    pos_t p;
    p.row = '0;
    for (int r = 1; r < GRID_SIDE; r++) begin
      if (idx >= IDX_W'(r * GRID_SIDE)) p.row = RC_W'(r);
    end
    p.col = RC_W'(idx - IDX_W'(p.row) * IDX_W'(GRID_SIDE));
    return p;
  endfunction

  function automatic logic [IDX_W-1:0] pos_to_idx(input pos_t p);
    return IDX_W'(p.row) * IDX_W'(GRID_SIDE) + IDX_W'(p.col);
  endfunction

  function automatic logic [RC_W-1:0] wrap_dec(input logic [RC_W-1:0] v);
    return (v == '0) ? RC_W'(GRID_SIDE - 1) : v - 1'b1;
  endfunction

endpackage

/* hdl/pfd_in_if.sv */
interface pfd_in_if;
  import pfd_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [LETTER_W-1:0] first_letter;
  logic [LETTER_W-1:0] second_letter;

  modport source (output valid, opcode, first_letter, second_letter, input ready);
  modport sink   (input valid, opcode, first_letter, second_letter, output ready);
endinterface

/* hdl/pfd_out_if.sv */
interface pfd_out_if;
  import pfd_pkg::*;

  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] plain_first;
  logic [LETTER_W-1:0] plain_second;
  logic                letter_missing;

  modport source (output valid, plain_first, plain_second, letter_missing, input ready);
  modport sink   (input valid, plain_first, plain_second, letter_missing, output ready);
endinterface

/* hdl/pfd_ram.sv */
module pfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/pfd_front.sv */
module pfd_front (
  input  logic          clk,
  input  logic          rst_n,
  pfd_in_if.sink        in_chan,
  output pfd_pkg::cmd_t head,
  output logic          head_valid,
  input  logic          head_pop
);
  import pfd_pkg::*;

  localparam int QDEPTH = 2;

  cmd_t                        q_r [QDEPTH];
  logic [$clog2(QDEPTH)-1:0]   wr_ptr_r, rd_ptr_r;
  logic [$clog2(QDEPTH+1)-1:0] count_r;
  cmd_t                        cmd_in;
  logic                        push, pop;

  always_comb begin
    cmd_in.op         = opcode_t'(in_chan.opcode);
    cmd_in.first      = in_chan.first_letter;
    cmd_in.second     = in_chan.second_letter;
    cmd_in.first_bad  = letter_bad(in_chan.first_letter);
    cmd_in.second_bad = letter_bad(in_chan.second_letter);
  end

  assign in_chan.ready = (count_r != ($clog2(QDEPTH+1))'(QDEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign head_valid    = (count_r != '0);
  assign pop           = head_pop && head_valid;
  assign head          = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

/* hdl/pfd_back.sv */
module pfd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  pfd_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          head_pop,
  pfd_out_if.source     out_chan
);
  import pfd_pkg::*;

  back_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]    fill_r, fill_nxt;
  logic [ALPHABET-1:0] used_r, used_nxt;
  logic [LETTER_W-1:0] n_r, n_nxt;
  logic [LETTER_W-1:0] b_r, b_nxt;
  logic                miss_r, miss_nxt;
  pos_t                rc1_r, rc1_nxt;
  logic [IDX_W-1:0]    p2_idx_r, p2_idx_nxt;
  logic [LETTER_W-1:0] plain1_r, plain1_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [LETTER_W-1:0] out_first_r, out_first_nxt;
  logic [LETTER_W-1:0] out_second_r, out_second_nxt;
  logic                out_missing_r, out_missing_nxt;

  logic                place_en;
  logic [LETTER_W-1:0] place_letter;
  logic                pos_rd_en, cell_rd_en;
  logic [LETTER_W-1:0] pos_rd_addr;
  logic [IDX_W-1:0]    cell_rd_addr;
  pos_t                pos_rd_data, rc2, np1, np2;
  logic [LETTER_W-1:0] cell_rd_data;
  logic                out_free;
  logic                full;

  assign full     = (fill_r == IDX_W'(CELL_COUNT));
  assign out_free = !out_valid_r || out_chan.ready;
  assign rc2      = pos_rd_data;

  // Decrypt rules on the two found positions
  always_comb begin
    np1 = rc1_r;
    np2 = rc2;
    if (rc1_r.row == rc2.row) begin
      np1.col = wrap_dec(rc1_r.col);
      np2.col = wrap_dec(rc2.col);
    end else if (rc1_r.col == rc2.col) begin
      np1.row = wrap_dec(rc1_r.row);
      np2.row = wrap_dec(rc2.row);
    end else begin
      np1.col = rc2.col;
      np2.col = rc1_r.col;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    used_nxt        = used_r;
    n_nxt           = n_r;
    b_nxt           = b_r;
    miss_nxt        = miss_r;
    rc1_nxt         = rc1_r;
    p2_idx_nxt      = p2_idx_r;
    plain1_nxt      = plain1_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_first_nxt   = out_first_r;
    out_second_nxt  = out_second_r;
    out_missing_nxt = out_missing_r;
    head_pop        = 1'b0;
    place_en        = 1'b0;
    place_letter    = head.first;
    pos_rd_en       = 1'b0;
    pos_rd_addr     = head.first;
    cell_rd_en      = 1'b0;
    cell_rd_addr    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          head_pop = 1'b1;
          unique case (head.op)
            OP_KEY: begin
              place_en = !head.first_bad && !used_r[head.first] && !full;
            end
            OP_FINISH: begin
              n_nxt     = '0;
              state_nxt = ST_FILL;
            end
            OP_CLEAR: begin
              used_nxt = '0;
              fill_nxt = '0;
            end
            OP_DECRYPT: begin
              // a full square holds every letter but j
              miss_nxt = !full || head.first_bad || head.second_bad;
              b_nxt    = head.second;
              if (!full || head.first_bad || head.second_bad) begin
                state_nxt = ST_EMIT;
              end else begin
                pos_rd_en = 1'b1;
                state_nxt = ST_POS_B;
              end
            end
          endcase
        end
      end
      ST_FILL: begin
        place_letter = n_r;
        place_en     = (n_r != LETTER_W'(LETTER_J)) && !used_r[n_r] && !full;
        n_nxt        = n_r + 1'b1;
        if (n_r == LETTER_W'(ALPHABET - 1)) state_nxt = ST_IDLE;
      end
      ST_POS_B: begin
        rc1_nxt     = pos_rd_data;
        pos_rd_en   = 1'b1;
        pos_rd_addr = b_r;
        state_nxt   = ST_CALC;
      end
      ST_CALC: begin
        cell_rd_en   = 1'b1;
        cell_rd_addr = pos_to_idx(np1);
        p2_idx_nxt   = pos_to_idx(np2);
        state_nxt    = ST_CELL2;
      end
      ST_CELL2: begin
        plain1_nxt   = cell_rd_data;
        cell_rd_en   = 1'b1;
        cell_rd_addr = p2_idx_r;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_first_nxt   = miss_r ? '0 : plain1_r;
          out_second_nxt  = miss_r ? '0 : cell_rd_data;
          out_missing_nxt = miss_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (place_en) begin
      used_nxt[place_letter] = 1'b1;
      fill_nxt               = fill_r + 1'b1;
    end
  end

  pfd_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (CELL_COUNT)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (place_en),
    .wr_addr (fill_r[$clog2(CELL_COUNT)-1:0]),
    .wr_data (place_letter),
    .rd_en   (cell_rd_en),
    .rd_addr (cell_rd_addr[$clog2(CELL_COUNT)-1:0]),
    .rd_data (cell_rd_data)
  );

  pfd_ram #(
    .WIDTH (POS_W),
    .DEPTH (ALPHABET)
  ) u_pos_ram (
    .clk     (clk),
    .wr_en   (place_en),
    .wr_addr (place_letter),
    .wr_data (idx_to_pos(fill_r)),
    .rd_en   (pos_rd_en),
    .rd_addr (pos_rd_addr),
    .rd_data (pos_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r           <= n_nxt;
    b_r           <= b_nxt;
    miss_r        <= miss_nxt;
    rc1_r         <= rc1_nxt;
    p2_idx_r      <= p2_idx_nxt;
    plain1_r      <= plain1_nxt;
    out_first_r   <= out_first_nxt;
    out_second_r  <= out_second_nxt;
    out_missing_r <= out_missing_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.plain_first    = out_first_r;
  assign out_chan.plain_second   = out_second_r;
  assign out_chan.letter_missing = out_missing_r;

endmodule

/* hdl/playfair_digraph_decrypt_top.sv */
// channel   dir  payload                                      transfer
// in_chan   in   opcode, first_letter, second_letter          valid && ready
// out_chan  out  plain_first, plain_second, letter_missing    valid && ready
//
// Back end: key and clear act at dispatch; finish is dispatch plus a 26-letter walk; decrypt does
// two registered reads of the letter-to-position RAM, two of the cell RAM, then the
// output load; a flagged decrypt (j, past z, square not full) skips to the load.
// A 2-entry command queue lets the input side keep transferring during that work.
// Reset (rst_n low, synchronous) empties the square, the queue and the output register.
// The back end waits in its last decrypt cycle while a previous result is untaken.
module playfair_digraph_decrypt_top (
  input  logic       clk,
  input  logic       rst_n,
  pfd_in_if.sink     in_chan,
  pfd_out_if.source  out_chan
);
  import pfd_pkg::*;

  cmd_t head;
  logic head_valid;
  logic head_pop;

  pfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  pfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .out_chan   (out_chan)
  );

endmodule

/* test/playfair_digraph_decrypt_top_test.sv */
module playfair_digraph_decrypt_top_test;
  import pfd_pkg::*;

  localparam int RAND_ITEMS  = 1200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 40;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [LETTER_W-1:0] first;
    logic [LETTER_W-1:0] second;
    logic                drain;  // hold this command until all results are back
  } pf_cmd_t;

  typedef struct packed {
    logic [LETTER_W-1:0] first;
    logic [LETTER_W-1:0] second;
    logic                missing;
  } plain_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pfd_in_if  in_chan ();
  pfd_out_if out_chan ();

  playfair_digraph_decrypt_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pf_cmd_t pending_cmds[$];
  plain_t  expected_plain[$];
  pf_cmd_t cur_cmd;
  int      total_items = 0;
  int      n_sent = 0;
  int      n_cycles = 0;
  int      n_errors = 0;
  int      n_results = 0;
  int      n_row = 0, n_col = 0, n_rect = 0, n_flagged = 0;

  // predicted square
  logic [LETTER_W-1:0] sq_cell [CELL_COUNT];
  logic [ALPHABET-1:0] sq_used = '0;
  int                  sq_fill = 0;

  task automatic place_letter(input int l);
    if (sq_fill < CELL_COUNT) begin
      sq_cell[sq_fill] = LETTER_W'(l);
      sq_used[l] = 1'b1;
      sq_fill++;
    end
  endtask

  function automatic bit locate(input logic [LETTER_W-1:0] l, output int r, output int c);
    r = 0;
    c = 0;
    if (l >= ALPHABET || l == LETTER_J) return 1'b0;
    for (int i = 0; i < CELL_COUNT; i++) begin
      if (sq_cell[i] == l) begin
        r = i / GRID_SIDE;
        c = i % GRID_SIDE;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [LETTER_W-1:0] sq_at(input int r, input int c);
    return sq_cell[(r % GRID_SIDE) * GRID_SIDE + (c % GRID_SIDE)];
  endfunction

  task automatic decrypt_pair(input logic [LETTER_W-1:0] a, input logic [LETTER_W-1:0] b);
    int r1, c1, r2, c2;
    plain_t p;
    p = '0;
    if (sq_fill < CELL_COUNT || !locate(a, r1, c1) || !locate(b, r2, c2)) begin
      p.missing = 1'b1;
      n_flagged++;
    end else if (r1 == r2) begin
      p.first  = sq_at(r1, c1 + GRID_SIDE - 1);
      p.second = sq_at(r2, c2 + GRID_SIDE - 1);
      n_row++;
    end else if (c1 == c2) begin
      p.first  = sq_at(r1 + GRID_SIDE - 1, c1);
      p.second = sq_at(r2 + GRID_SIDE - 1, c2);
      n_col++;
    end else begin
      p.first  = sq_at(r1, c2);
      p.second = sq_at(r2, c1);
      n_rect++;
    end
    expected_plain.push_back(p);
  endtask

  task automatic predict_command(input pf_cmd_t c);
    case (c.op)
      OP_KEY: begin
        if (c.first < ALPHABET && c.first != LETTER_J && !sq_used[c.first])
          place_letter(c.first);
      end
      OP_FINISH: begin
        for (int n = 0; n < ALPHABET; n++)
          if (n != LETTER_J && !sq_used[n]) place_letter(n);
      end
      OP_CLEAR: begin
        sq_used = '0;
        sq_fill = 0;
      end
      default: decrypt_pair(c.first, c.second);
    endcase
  endtask

  task automatic add_cmd(input opcode_t op, input int a, input int b, input bit drain = 1'b0);
    pf_cmd_t c;
    c.op     = op;
    c.first  = LETTER_W'(a);
    c.second = LETTER_W'(b);
    c.drain  = drain;
    pending_cmds.push_back(c);
  endtask

  function automatic int any_code();
    return $urandom_range(31);
  endfunction

  function automatic int key_code();
    return ($urandom_range(11) == 0) ? $urandom_range(31) : $urandom_range(25);
  endfunction

  function automatic int cipher_code();
    return ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(25);
  endfunction

  // thirds of the run: receiver idles more, then sender idles more, then no idling
  function automatic int idle_phase();
    if (n_sent * 3 < total_items) return 0;
    if (n_sent * 3 < total_items * 2) return 1;
    return 2;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", n_cycles, what, got, want);
    n_errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid         <= 1'b0;
      in_chan.opcode        <= '0;
      in_chan.first_letter  <= '0;
      in_chan.second_letter <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        predict_command(cur_cmd);
        n_sent <= n_sent + 1;
      end
      if (in_chan.valid && !in_chan.ready) begin
        // keep offering the same transfer
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].drain && expected_plain.size() != 0) &&
                   $urandom_range(99) >= (idle_phase() == 0 ? 38 :
                                          idle_phase() == 1 ? 68 : 0)) begin
        cur_cmd = pending_cmds.pop_front();
        in_chan.valid         <= 1'b1;
        in_chan.opcode        <= cur_cmd.op;
        in_chan.first_letter  <= cur_cmd.first;
        in_chan.second_letter <= cur_cmd.second;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n)
      out_chan.ready <= 1'b0;
    else
      out_chan.ready <= $urandom_range(99) >= (idle_phase() == 0 ? 68 :
                                               idle_phase() == 1 ? 38 : 0);
  end

  // monitor: outputs are stable mid-cycle, so a transfer seen here lands at the next edge
  always @(negedge clk) begin
    plain_t w;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      n_results++;
      if (expected_plain.size() == 0) begin
        report("unexpected result, plain_first", out_chan.plain_first, 0);
      end else begin
        w = expected_plain.pop_front();
        if (out_chan.plain_first !== w.first)
          report("plain_first", out_chan.plain_first, w.first);
        if (out_chan.plain_second !== w.second)
          report("plain_second", out_chan.plain_second, w.second);
        if (out_chan.letter_missing !== w.missing)
          report("letter_missing", out_chan.letter_missing, w.missing);
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d commands sent, %0d results open",
               n_cycles, n_sent, total_items, expected_plain.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int n_directed, nkey, ndig, seq, a;

    // decrypt on an empty square
    add_cmd(OP_DECRYPT, 0, 25);
    // key "playfair" with a repeat, a j and an out-of-range code mixed in
    add_cmd(OP_KEY, 15, 0);
    add_cmd(OP_KEY, 11, 31);
    add_cmd(OP_KEY, 0, 0);
    add_cmd(OP_KEY, 24, 0);
    add_cmd(OP_KEY, 5, 0);
    add_cmd(OP_KEY, 0, 0);
    add_cmd(OP_KEY, 9, 0);
    add_cmd(OP_KEY, 31, 0);
    add_cmd(OP_KEY, 8, 0);
    add_cmd(OP_KEY, 17, 0);
    add_cmd(OP_FINISH, 31, 31);
    add_cmd(OP_FINISH, 0, 0, 1'b1);  // already full
    add_cmd(OP_KEY, 25, 0);          // square full
    add_cmd(OP_DECRYPT, 11, 5);      // same row
    add_cmd(OP_DECRYPT, 15, 20);     // same column, wraps
    add_cmd(OP_DECRYPT, 0, 16);      // same column
    add_cmd(OP_DECRYPT, 24, 24);     // equal letters
    add_cmd(OP_DECRYPT, 9, 0);       // j
    add_cmd(OP_DECRYPT, 0, 31);      // past z
    add_cmd(OP_DECRYPT, 25, 0);
    add_cmd(OP_DECRYPT, 31, 31);
    add_cmd(OP_CLEAR, 0, 0);
    add_cmd(OP_DECRYPT, 15, 11);     // after clear
    n_directed = pending_cmds.size();

    seq = 0;
    while (pending_cmds.size() < n_directed + RAND_ITEMS) begin
      if ($urandom_range(99) < 85) begin
        add_cmd(OP_CLEAR, any_code(), any_code(), seq % 40 == 0);
        nkey = $urandom_range(30);
        for (int k = 0; k < nkey; k++) add_cmd(OP_KEY, key_code(), any_code());
        if ($urandom_range(9) != 0) add_cmd(OP_FINISH, any_code(), any_code());
        if ($urandom_range(7) == 0) add_cmd(OP_FINISH, any_code(), any_code());
        if ($urandom_range(7) == 0) add_cmd(OP_KEY, key_code(), any_code());
        ndig = $urandom_range(2, 12);
        for (int d = 0; d < ndig; d++) begin
          a = cipher_code();
          add_cmd(OP_DECRYPT, a, ($urandom_range(7) == 0) ? a : cipher_code());
        end
      end else begin
        add_cmd(opcode_t'($urandom_range(3)), any_code(), any_code());
      end
      seq++;
    end
    total_items = pending_cmds.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_sent == total_items);
    wait (expected_plain.size() == 0);
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d commands (%0d directed, %0d key sequences) over three idle patterns",
             total_items, n_directed, seq);
    $display("checked %0d digraphs: %0d same row, %0d same column, %0d rectangle, %0d flagged",
             n_results, n_row, n_col, n_rect, n_flagged);
    if (n_errors == 0 && expected_plain.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
